FILE: sv/dalt_pkg.sv
// Shared constants, flag struct and arctangent table for the altimeter fusion core.
package dalt_pkg;

	localparam int SHARE_BITS    = 16;
	localparam int LIMIT_BITS    = 24;
	localparam int BASE_BITS     = 24;
	localparam int FRAC_BITS     = 16;
	localparam int ZW            = 32;
	localparam int ATAN_COUNT    = 24;
	localparam int SLOPE_BITS    = 15;
	localparam int SLOPE_LIMIT   = 9000;
	localparam int ROUND_HALF    = 32768;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 24;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LIDAR_SHARE     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DISAGREE_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SLOPE_BASE      = 2'd2;

	localparam logic [SHARE_BITS-1:0] SHARE_RESET = 16'd65373;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 24'd5000;
	localparam logic [BASE_BITS-1:0]  BASE_RESET  = 24'd10000;

	localparam logic [2:0] SRC_BLEND          = 3'd0;
	localparam logic [2:0] SRC_LIDAR_DISAGREE = 3'd1;
	localparam logic [2:0] SRC_LIDAR_ONLY     = 3'd2;
	localparam logic [2:0] SRC_RADAR_ONLY     = 3'd3;
	localparam logic [2:0] SRC_HELD           = 3'd4;

	typedef struct packed {
		logic       lidar_used;
		logic       radar_used;
		logic [2:0] src;
		logic       base_zero;
		logic       dy_pos;
		logic       dy_neg;
	} flags_t;

	// arctangent of 2^-i in centidegrees scaled by 2^16, rounded
	function automatic logic signed [ZW-1:0] atan_of(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0:       v = 32'sd294912000;
			1:       v = 32'sd174096719;
			2:       v = 32'sd91987925;
			3:       v = 32'sd46694507;
			4:       v = 32'sd23437865;
			5:       v = 32'sd11730358;
			6:       v = 32'sd5866610;
			7:       v = 32'sd2933484;
			8:       v = 32'sd1466764;
			9:       v = 32'sd733385;
			10:      v = 32'sd366693;
			11:      v = 32'sd183346;
			12:      v = 32'sd91673;
			13:      v = 32'sd45837;
			14:      v = 32'sd22918;
			15:      v = 32'sd11459;
			16:      v = 32'sd5730;
			17:      v = 32'sd2865;
			18:      v = 32'sd1432;
			19:      v = 32'sd716;
			20:      v = 32'sd358;
			21:      v = 32'sd179;
			22:      v = 32'sd90;
			23:      v = 32'sd45;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/dual_altimeter_fusion_core.sv
// Dual altimeter fusion core: top level with configuration registers and the CORDIC cell row.
//
// Takes one word per clock, each carrying a lidar and a radar reading, and returns one fused
// word per input: blended, lidar or radar height and rate, with the source chosen from the
// good flags and the disagreement limit, plus the terrain slope atan2(height change,
// slope_base_mm) in centidegrees. The pipeline registers are the two blend stages
// (products, then rounding and source choice), one register per CORDIC cell and the output
// register; throughput is one word per cycle and a stalled master side holds each stage in
// turn, so bubbles still fill behind it. The previous height lives in the second blend stage
// and resets to zero. Configuration writes are taken at any time (cfg_ready is always high)
// but should be made only with the pipeline empty.
module dual_altimeter_fusion_core import dalt_pkg::*; #(
	parameter int RANGE_BITS    = 24,
	parameter int RATE_BITS     = 21,
	parameter int CORDIC_STAGES = 16,
	localparam int IN_W  = ((2 * (RANGE_BITS + RATE_BITS) + 7) / 8) * 8,
	localparam int OUT_W = ((RANGE_BITS + RATE_BITS + SLOPE_BITS + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// lidar_range_mm, lidar_rate, radar_range_mm, radar_rate
	input  logic [IN_W-1:0]          s_axis_tdata,
	// lidar_good, radar_good
	input  logic [1:0]               s_axis_tuser,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// height_mm, vert_rate, slope_centideg
	output logic [OUT_W-1:0]         m_axis_tdata,
	// lidar_used_ok, radar_used_ok, source[2:0]
	output logic [4:0]               m_axis_tuser,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int CW = (RANGE_BITS > BASE_BITS ? RANGE_BITS : BASE_BITS) + FRAC_BITS + 4;

	// configuration registers
	logic [SHARE_BITS-1:0] lidar_share_q;
	logic [LIMIT_BITS-1:0] disagree_limit_q;
	logic [BASE_BITS-1:0]  slope_base_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lidar_share_q    <= SHARE_RESET;
			disagree_limit_q <= LIMIT_RESET;
			slope_base_q     <= BASE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LIDAR_SHARE:    lidar_share_q    <= cfg_data[SHARE_BITS-1:0];
				CFG_DISAGREE_LIMIT: disagree_limit_q <= cfg_data[LIMIT_BITS-1:0];
				CFG_SLOPE_BASE:     slope_base_q     <= cfg_data[BASE_BITS-1:0];
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	// blend front end
	logic                         b_valid, b_ready;
	logic [RANGE_BITS-1:0]        b_height, b_prev;
	logic signed [RATE_BITS-1:0]  b_rate;
	flags_t                       b_flags;

	dalt_blend #(
		.RANGE_BITS (RANGE_BITS),
		.RATE_BITS  (RATE_BITS)
	) u_blend (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (s_axis_tvalid),
		.in_ready          (s_axis_tready),
		.lidar_range_mm    (s_axis_tdata[RANGE_BITS-1:0]),
		.lidar_rate        ($signed(s_axis_tdata[RANGE_BITS+RATE_BITS-1:RANGE_BITS])),
		.lidar_good        (s_axis_tuser[0]),
		.radar_range_mm    (s_axis_tdata[2*RANGE_BITS+RATE_BITS-1:RANGE_BITS+RATE_BITS]),
		.radar_rate        ($signed(s_axis_tdata[2*(RANGE_BITS+RATE_BITS)-1:
			2*RANGE_BITS+RATE_BITS])),
		.radar_good        (s_axis_tuser[1]),
		.lidar_share       (lidar_share_q),
		.disagree_limit_mm (disagree_limit_q),
		.out_valid         (b_valid),
		.out_ready         (b_ready),
		.height_mm         (b_height),
		.vert_rate         (b_rate),
		.prev_height       (b_prev),
		.flags             (b_flags)
	);

	// vector set-up for the first cell
	logic signed [RANGE_BITS:0] dy;
	flags_t                     flags0;

	assign dy = $signed({1'b0, b_height}) - $signed({1'b0, b_prev});

	always_comb begin
		flags0           = b_flags;
		flags0.base_zero = (slope_base_q == '0);
		flags0.dy_pos    = !dy[RANGE_BITS] && (dy != '0);
		flags0.dy_neg    = dy[RANGE_BITS];
	end

	logic signed [CW-1:0]         cx     [CORDIC_STAGES+1];
	logic signed [CW-1:0]         cy     [CORDIC_STAGES+1];
	logic signed [ZW-1:0]         cz     [CORDIC_STAGES+1];
	flags_t                       cflags [CORDIC_STAGES+1];
	logic [RANGE_BITS-1:0]        cheight[CORDIC_STAGES+1];
	logic signed [RATE_BITS-1:0]  crate  [CORDIC_STAGES+1];
	logic                         cvalid [CORDIC_STAGES+1];
	logic                         cready [CORDIC_STAGES+1];

	assign cx[0]      = $signed({{(CW-BASE_BITS){1'b0}}, slope_base_q}) <<< FRAC_BITS;
	assign cy[0]      = $signed({{(CW-RANGE_BITS-1){dy[RANGE_BITS]}}, dy}) <<< FRAC_BITS;
	assign cz[0]      = '0;
	assign cflags[0]  = flags0;
	assign cheight[0] = b_height;
	assign crate[0]   = b_rate;
	assign cvalid[0]  = b_valid;
	assign b_ready    = cready[0];

	// row of CORDIC cells, one iteration each
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		dalt_cordic_cell #(
			.CW         (CW),
			.RANGE_BITS (RANGE_BITS),
			.RATE_BITS  (RATE_BITS),
			.STAGE      (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (cvalid[i]),
			.in_ready   (cready[i]),
			.x_in       (cx[i]),
			.y_in       (cy[i]),
			.z_in       (cz[i]),
			.flags_in   (cflags[i]),
			.height_in  (cheight[i]),
			.rate_in    (crate[i]),
			.out_valid  (cvalid[i+1]),
			.out_ready  (cready[i+1]),
			.x_out      (cx[i+1]),
			.y_out      (cy[i+1]),
			.z_out      (cz[i+1]),
			.flags_out  (cflags[i+1]),
			.height_out (cheight[i+1]),
			.rate_out   (crate[i+1])
		);
	end

	// output stage
	logic [RANGE_BITS-1:0]        out_height;
	logic signed [RATE_BITS-1:0]  out_rate;
	logic signed [SLOPE_BITS-1:0] out_slope;
	flags_t                       out_flags;

	dalt_slope_out #(
		.RANGE_BITS (RANGE_BITS),
		.RATE_BITS  (RATE_BITS)
	) u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (cvalid[CORDIC_STAGES]),
		.in_ready       (cready[CORDIC_STAGES]),
		.z_in           (cz[CORDIC_STAGES]),
		.flags_in       (cflags[CORDIC_STAGES]),
		.height_in      (cheight[CORDIC_STAGES]),
		.rate_in        (crate[CORDIC_STAGES]),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.height_mm      (out_height),
		.vert_rate      (out_rate),
		.slope_centideg (out_slope),
		.flags_out      (out_flags)
	);

	assign m_axis_tdata = OUT_W'({out_slope, out_rate, out_height});
	assign m_axis_tuser = {out_flags.src, out_flags.radar_used, out_flags.lidar_used};

	a_held_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_flags.src == SRC_HELD) |-> (out_rate == '0))
		else $error("held word carries a non-zero rate");

	a_slope_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_slope <= $signed(SLOPE_BITS'(SLOPE_LIMIT))
			&& out_slope >= -$signed(SLOPE_BITS'(SLOPE_LIMIT))))
		else $error("slope outside +-90 degrees");

	a_no_lidar_src: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !out_flags.lidar_used)
			|-> (out_flags.src == SRC_RADAR_ONLY || out_flags.src == SRC_HELD))
		else $error("lidar-based source without a good lidar word");

	a_no_radar_src: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !out_flags.radar_used)
			|-> (out_flags.src == SRC_LIDAR_ONLY || out_flags.src == SRC_HELD))
		else $error("radar-based source without a good radar word");

	a_both_src: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_flags.lidar_used && out_flags.radar_used)
			|-> (out_flags.src == SRC_BLEND || out_flags.src == SRC_LIDAR_DISAGREE))
		else $error("two good sensors but single-sensor source");

endmodule

FILE: sv/dalt_blend.sv
// Two-stage source selection and Q0.16 blend of lidar and radar readings; holds last height.
module dalt_blend import dalt_pkg::*; #(
	parameter int RANGE_BITS = 24,
	parameter int RATE_BITS  = 21
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [RANGE_BITS-1:0]        lidar_range_mm,
	input  logic signed [RATE_BITS-1:0]  lidar_rate,
	input  logic                         lidar_good,
	input  logic [RANGE_BITS-1:0]        radar_range_mm,
	input  logic signed [RATE_BITS-1:0]  radar_rate,
	input  logic                         radar_good,
	input  logic [SHARE_BITS-1:0]        lidar_share,
	input  logic [LIMIT_BITS-1:0]        disagree_limit_mm,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [RANGE_BITS-1:0]        height_mm,
	output logic signed [RATE_BITS-1:0]  vert_rate,
	output logic [RANGE_BITS-1:0]        prev_height,
	output flags_t                       flags
);

	localparam int DW = (RANGE_BITS > LIMIT_BITS ? RANGE_BITS : LIMIT_BITS) + 1;
	localparam int HPW = RANGE_BITS + SHARE_BITS + 2;
	localparam int RPW = RATE_BITS + SHARE_BITS + 2;

	// stage 1: difference, disagreement test, products
	logic signed [RANGE_BITS:0]   hdiff;
	logic [RANGE_BITS:0]          hmag;
	logic                         disagree;
	logic signed [RATE_BITS:0]    rdiff;
	logic signed [HPW-1:0]        prod_h;
	logic signed [RPW-1:0]        prod_r;

	assign hdiff    = $signed({1'b0, lidar_range_mm}) - $signed({1'b0, radar_range_mm});
	assign hmag     = hdiff[RANGE_BITS] ? $unsigned(-hdiff) : $unsigned(hdiff);
	assign disagree = DW'(hmag) > DW'(disagree_limit_mm);
	assign rdiff    = {lidar_rate[RATE_BITS-1], lidar_rate}
		- {radar_rate[RATE_BITS-1], radar_rate};
	assign prod_h   = $signed({1'b0, lidar_share}) * hdiff;
	assign prod_r   = $signed({1'b0, lidar_share}) * rdiff;

	logic                         v_s1;
	logic                         rdy_s1;
	logic [RANGE_BITS-1:0]        lr_s1, rr_s1;
	logic signed [RATE_BITS-1:0]  lrate_s1, rrate_s1;
	logic                         lok_s1, rok_s1, disagree_s1;
	logic signed [HPW-1:0]        prod_h_s1;
	logic signed [RPW-1:0]        prod_r_s1;

	logic                         v_s2;
	logic                         rdy_s2;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			lr_s1       <= lidar_range_mm;
			rr_s1       <= radar_range_mm;
			lrate_s1    <= lidar_rate;
			rrate_s1    <= radar_rate;
			lok_s1      <= lidar_good;
			rok_s1      <= radar_good;
			disagree_s1 <= disagree;
			prod_h_s1   <= prod_h;
			prod_r_s1   <= prod_r;
		end
	end

	// stage 2: round, add to radar, select source
	logic signed [HPW-1:0]        sum_h;
	logic signed [RPW-1:0]        sum_r;
	logic signed [RANGE_BITS+1:0] blend_h;
	logic signed [RATE_BITS+1:0]  blend_r;
	logic [RANGE_BITS-1:0]        h_sel;
	logic signed [RATE_BITS-1:0]  r_sel;
	logic [2:0]                   src_sel;
	logic [RANGE_BITS-1:0]        last_height_q;

	assign sum_h   = prod_h_s1 + $signed(HPW'(ROUND_HALF));
	assign sum_r   = prod_r_s1 + $signed(RPW'(ROUND_HALF));
	assign blend_h = $signed({2'b00, rr_s1}) + $signed(sum_h[HPW-1:FRAC_BITS]);
	assign blend_r = $signed({{2{rrate_s1[RATE_BITS-1]}}, rrate_s1})
		+ $signed(sum_r[RPW-1:FRAC_BITS]);

	always_comb begin
		priority if (lok_s1 && rok_s1 && disagree_s1) begin
			h_sel   = lr_s1;
			r_sel   = lrate_s1;
			src_sel = SRC_LIDAR_DISAGREE;
		end else if (lok_s1 && rok_s1) begin
			h_sel   = blend_h[RANGE_BITS-1:0];
			r_sel   = blend_r[RATE_BITS-1:0];
			src_sel = SRC_BLEND;
		end else if (lok_s1) begin
			h_sel   = lr_s1;
			r_sel   = lrate_s1;
			src_sel = SRC_LIDAR_ONLY;
		end else if (rok_s1) begin
			h_sel   = rr_s1;
			r_sel   = rrate_s1;
			src_sel = SRC_RADAR_ONLY;
		end else begin
			h_sel   = last_height_q;
			r_sel   = '0;
			src_sel = SRC_HELD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2          <= 1'b0;
			last_height_q <= '0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				last_height_q <= h_sel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			height_mm        <= h_sel;
			vert_rate        <= r_sel;
			prev_height      <= last_height_q;
			flags.lidar_used <= lok_s1;
			flags.radar_used <= rok_s1;
			flags.src        <= src_sel;
			// slope-related flags are filled in downstream
			flags.base_zero  <= 1'b0;
			flags.dy_pos     <= 1'b0;
			flags.dy_neg     <= 1'b0;
		end
	end

	assign out_valid = v_s2;

endmodule

FILE: sv/dalt_cordic_cell.sv
// One vectoring CORDIC iteration with its own pipeline register and carried item fields.
module dalt_cordic_cell import dalt_pkg::*; #(
	parameter int CW         = 44,
	parameter int RANGE_BITS = 24,
	parameter int RATE_BITS  = 21,
	parameter int STAGE      = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [CW-1:0]         x_in,
	input  logic signed [CW-1:0]         y_in,
	input  logic signed [ZW-1:0]         z_in,
	input  flags_t                       flags_in,
	input  logic [RANGE_BITS-1:0]        height_in,
	input  logic signed [RATE_BITS-1:0]  rate_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [CW-1:0]         x_out,
	output logic signed [CW-1:0]         y_out,
	output logic signed [ZW-1:0]         z_out,
	output flags_t                       flags_out,
	output logic [RANGE_BITS-1:0]        height_out,
	output logic signed [RATE_BITS-1:0]  rate_out
);

	logic signed [CW-1:0] xs, ys, x_nx, y_nx;
	logic signed [ZW-1:0] z_nx;
	logic                 v_q;

	assign xs = x_in >>> STAGE;
	assign ys = y_in >>> STAGE;

	// rotate towards the x axis
	always_comb begin
		if (!y_in[CW-1]) begin
			x_nx = x_in + ys;
			y_nx = y_in - xs;
			z_nx = z_in + atan_of(STAGE);
		end else begin
			x_nx = x_in - ys;
			y_nx = y_in + xs;
			z_nx = z_in - atan_of(STAGE);
		end
	end

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_out      <= x_nx;
			y_out      <= y_nx;
			z_out      <= z_nx;
			flags_out  <= flags_in;
			height_out <= height_in;
			rate_out   <= rate_in;
		end
	end

endmodule

FILE: sv/dalt_slope_out.sv
// Angle rounding, clamping and the output register of the fusion core.
module dalt_slope_out import dalt_pkg::*; #(
	parameter int RANGE_BITS = 24,
	parameter int RATE_BITS  = 21
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [ZW-1:0]          z_in,
	input  flags_t                        flags_in,
	input  logic [RANGE_BITS-1:0]         height_in,
	input  logic signed [RATE_BITS-1:0]   rate_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [RANGE_BITS-1:0]         height_mm,
	output logic signed [RATE_BITS-1:0]   vert_rate,
	output logic signed [SLOPE_BITS-1:0]  slope_centideg,
	output flags_t                        flags_out
);

	localparam int RW = ZW - FRAC_BITS;

	logic signed [ZW-1:0]         z_rnd;
	logic signed [RW-1:0]         r_deg;
	logic signed [SLOPE_BITS-1:0] slope_nx;
	logic                         v_q;

	assign z_rnd = z_in + $signed(ZW'(ROUND_HALF));
	assign r_deg = z_rnd[ZW-1:FRAC_BITS];

	always_comb begin
		priority if (flags_in.base_zero) begin
			// vertical reference: straight up, straight down or flat
			if (flags_in.dy_pos) begin
				slope_nx = SLOPE_BITS'(SLOPE_LIMIT);
			end else if (flags_in.dy_neg) begin
				slope_nx = -$signed(SLOPE_BITS'(SLOPE_LIMIT));
			end else begin
				slope_nx = '0;
			end
		end else if (r_deg > $signed(RW'(SLOPE_LIMIT))) begin
			slope_nx = SLOPE_BITS'(SLOPE_LIMIT);
		end else if (r_deg < -$signed(RW'(SLOPE_LIMIT))) begin
			slope_nx = -$signed(SLOPE_BITS'(SLOPE_LIMIT));
		end else begin
			slope_nx = r_deg[SLOPE_BITS-1:0];
		end
	end

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			height_mm      <= height_in;
			vert_rate      <= rate_in;
			slope_centideg <= slope_nx;
			flags_out      <= flags_in;
		end
	end

endmodule

FILE: tb/dual_altimeter_fusion_core_test.sv
// Self-checking testbench for dual_altimeter_fusion_core: directed and random reading pairs
`timescale 1ns / 100ps

module dual_altimeter_fusion_core_test;
	import dalt_pkg::*;

	localparam int RANGE_W    = 24;
	localparam int RATE_W     = 21;
	localparam int STAGES     = 16;
	localparam int LATENCY    = STAGES + 3;
	localparam longint RANGE_MAX = (64'sd1 << RANGE_W) - 1;
	localparam longint RATE_MAX  = (64'sd1 << (RATE_W - 1)) - 1;
	localparam longint RATE_MIN  = -(64'sd1 << (RATE_W - 1));

	// arctangent of 2^-i, centidegrees scaled by 2^16
	localparam longint ARCTAN_CDEG [24] = '{
		294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
		5866610, 2933484, 1466764, 733385, 366693, 183346,
		91673, 45837, 22918, 11459, 5730, 2865,
		1432, 716, 358, 179, 90, 45
	};

	typedef struct {
		logic [RANGE_W-1:0]        lidar_range;
		logic signed [RATE_W-1:0]  lidar_rate;
		logic                      lidar_good;
		logic [RANGE_W-1:0]        radar_range;
		logic signed [RATE_W-1:0]  radar_rate;
		logic                      radar_good;
	} reading_t;

	typedef struct {
		logic [RANGE_W-1:0]        height;
		logic signed [RATE_W-1:0]  rate;
		logic signed [14:0]        slope;
		logic                      lidar_used;
		logic                      radar_used;
		logic [2:0]                src;
	} fused_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic [95:0]              s_axis_tdata = '0;
	logic [1:0]               s_axis_tuser = '0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [63:0]              m_axis_tdata;
	logic [4:0]               m_axis_tuser;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_LIDAR_SHARE;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	dual_altimeter_fusion_core #(
		.RANGE_BITS(RANGE_W),
		.RATE_BITS(RATE_W),
		.CORDIC_STAGES(STAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// predictor state and register copies
	longint share_reg = SHARE_RESET;
	longint limit_reg = LIMIT_RESET;
	longint base_reg  = BASE_RESET;
	longint last_height = 0;

	reading_t pending_readings [$];
	fused_t   fused_due [$];
	reading_t cur_reading;
	bit       in_fire = 1'b0;
	bit       idle_on = 1'b1;
	int       gap_left = 0;
	int       stall_left = 0;
	int       mismatch_cnt = 0;
	longint   gen_prev = 0;

	function automatic longint weigh(longint a, longint b, longint share);
		return b + ((share * (a - b) + ROUND_HALF) >>> FRAC_BITS);
	endfunction

	function automatic longint terrain_slope(longint dy, longint base);
		longint x, y, z, xs, ys, r;
		int i;
		if (base == 0)
			return dy > 0 ? SLOPE_LIMIT : (dy < 0 ? -SLOPE_LIMIT : 0);
		x = base * 65536;
		y = dy * 65536;
		z = 0;
		for (i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ARCTAN_CDEG[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ARCTAN_CDEG[i];
			end
		end
		r = (z + ROUND_HALF) >>> FRAC_BITS;
		if (r > SLOPE_LIMIT) r = SLOPE_LIMIT;
		if (r < -SLOPE_LIMIT) r = -SLOPE_LIMIT;
		return r;
	endfunction

	function automatic fused_t fuse_reading(reading_t rd);
		fused_t f;
		longint lr, rr, lrate, rrate, h, rate, diff;
		lr = rd.lidar_range;
		rr = rd.radar_range;
		lrate = rd.lidar_rate;
		rrate = rd.radar_rate;
		if (rd.lidar_good && rd.radar_good) begin
			diff = lr - rr;
			if (diff < 0) diff = -diff;
			if (diff > limit_reg) begin
				h = lr; rate = lrate; f.src = SRC_LIDAR_DISAGREE;
			end else begin
				h = weigh(lr, rr, share_reg);
				rate = weigh(lrate, rrate, share_reg);
				f.src = SRC_BLEND;
			end
		end else if (rd.lidar_good) begin
			h = lr; rate = lrate; f.src = SRC_LIDAR_ONLY;
		end else if (rd.radar_good) begin
			h = rr; rate = rrate; f.src = SRC_RADAR_ONLY;
		end else begin
			h = last_height; rate = 0; f.src = SRC_HELD;
		end
		f.height = h[RANGE_W-1:0];
		f.rate = rate[RATE_W-1:0];
		f.slope = 15'(terrain_slope(h - last_height, base_reg));
		f.lidar_used = rd.lidar_good;
		f.radar_used = rd.radar_good;
		last_height = h;
		return f;
	endfunction

	function automatic int draw_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic longint clip_range(longint v);
		if (v < 0) return 0;
		if (v > RANGE_MAX) return RANGE_MAX;
		return v;
	endfunction

	function automatic longint draw_rate();
		if ($urandom_range(0, 1))
			return longint'($signed(21'($urandom())));
		return longint'($urandom_range(0, 10000)) - 5000;
	endfunction

	function automatic reading_t make_reading(longint lr, longint lrate, bit lg,
			longint rr, longint rrate, bit rg);
		reading_t rd;
		rd.lidar_range = lr[RANGE_W-1:0];
		rd.lidar_rate = lrate[RATE_W-1:0];
		rd.lidar_good = lg;
		rd.radar_range = rr[RANGE_W-1:0];
		rd.radar_rate = rrate[RATE_W-1:0];
		rd.radar_good = rg;
		return rd;
	endfunction

	// mostly both-good pairs with the radar placed around the disagreement limit
	function automatic reading_t random_reading();
		int unsigned p;
		longint lr, rr, off, lrate, rrate;
		bit lg, rg;
		p = $urandom_range(0, 99);
		lg = (p < 75);
		rg = (p < 60) || (p >= 75 && p < 90);
		case ($urandom_range(0, 3))
			0: lr = $urandom() & RANGE_MAX;
			1: lr = $urandom_range(0, 30000);
			2: lr = RANGE_MAX - $urandom_range(0, 30000);
			default: lr = clip_range(gen_prev + $urandom_range(0, 4000) - 2000);
		endcase
		case ($urandom_range(0, 3))
			0: off = -1;
			1: off = (limit_reg > 0) ? longint'($urandom_range(0, 32'(limit_reg))) : 0;
			2: off = limit_reg + $urandom_range(0, 2) - 1;
			default: off = $urandom_range(0, 50);
		endcase
		if (off < 0)
			rr = $urandom() & RANGE_MAX;
		else if ($urandom_range(0, 1) && lr + off <= RANGE_MAX)
			rr = lr + off;
		else
			rr = clip_range(lr - off);
		lrate = draw_rate();
		rrate = $urandom_range(0, 1) ? draw_rate() : lrate + $urandom_range(0, 200) - 100;
		if (rrate > RATE_MAX) rrate = RATE_MAX;
		if (rrate < RATE_MIN) rrate = RATE_MIN;
		gen_prev = lr;
		return make_reading(lr, lrate, lg, rr, rrate, rg);
	endfunction

	// input driver: present a word at the falling edge, hold it until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && !in_fire) begin
				// hold
			end else if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_readings.size() > 0) begin
				cur_reading = pending_readings.pop_front();
				s_axis_tdata <= {6'b0, cur_reading.radar_rate, cur_reading.radar_range,
					cur_reading.lidar_rate, cur_reading.lidar_range};
				s_axis_tuser <= {cur_reading.radar_good, cur_reading.lidar_good};
				s_axis_tvalid <= 1'b1;
				gap_left = idle_on ? draw_gap() : 0;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		in_fire = s_axis_tvalid && s_axis_tready;
		if (arst_n && in_fire)
			fused_due.push_back(fuse_reading(cur_reading));
	end

	// output side: random stalls on tready
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left = idle_on ? draw_gap() : 0;
			end
		end
	end

	always @(posedge clk) begin
		fused_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.height = m_axis_tdata[23:0];
			got.rate = m_axis_tdata[44:24];
			got.slope = m_axis_tdata[59:45];
			got.lidar_used = m_axis_tuser[0];
			got.radar_used = m_axis_tuser[1];
			got.src = m_axis_tuser[4:2];
			if (fused_due.size() == 0) begin
				$error("unexpected output word: height_mm %0d", got.height);
				mismatch_cnt++;
			end else begin
				want = fused_due.pop_front();
				if (got.height !== want.height) begin
					$error("height_mm: expected %0d, got %0d", want.height, got.height);
					mismatch_cnt++;
				end
				if (got.rate !== want.rate) begin
					$error("vert_rate: expected %0d, got %0d", want.rate, got.rate);
					mismatch_cnt++;
				end
				if (got.slope !== want.slope) begin
					$error("slope_centideg: expected %0d, got %0d", want.slope, got.slope);
					mismatch_cnt++;
				end
				if (got.lidar_used !== want.lidar_used) begin
					$error("lidar_used_ok: expected %0d, got %0d", want.lidar_used,
						got.lidar_used);
					mismatch_cnt++;
				end
				if (got.radar_used !== want.radar_used) begin
					$error("radar_used_ok: expected %0d, got %0d", want.radar_used,
						got.radar_used);
					mismatch_cnt++;
				end
				if (got.src !== want.src) begin
					$error("source: expected %0d, got %0d", want.src, got.src);
					mismatch_cnt++;
				end
			end
		end
	end

	// wait for the pipeline to empty, then let it settle
	task automatic drain_pipeline();
		while (pending_readings.size() > 0 || s_axis_tvalid || fused_due.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic program_register(logic [CFG_IDX_BITS-1:0] idx, longint value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_BITS-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LIDAR_SHARE:    share_reg = value & 64'hFFFF;
			CFG_DISAGREE_LIMIT: limit_reg = value & 64'hFF_FFFF;
			CFG_SLOPE_BASE:     base_reg = value & 64'hFF_FFFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_registers(longint share, longint limit, longint base);
		program_register(CFG_LIDAR_SHARE, share);
		program_register(CFG_DISAGREE_LIMIT, limit);
		program_register(CFG_SLOPE_BASE, base);
	endtask

	task automatic queue_random(int n, bit with_idle);
		idle_on = with_idle;
		repeat (n) pending_readings.push_back(random_reading());
		drain_pipeline();
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset settings: held before any height, limit edge, extremes, big jumps
		pending_readings.push_back(make_reading(RANGE_MAX, RATE_MAX, 0, RANGE_MAX, RATE_MIN, 0));
		pending_readings.push_back(make_reading(0, 0, 1, 0, 0, 1));
		pending_readings.push_back(make_reading(RANGE_MAX, RATE_MAX, 1,
			RANGE_MAX - 5000, RATE_MIN, 1));
		pending_readings.push_back(make_reading(RANGE_MAX - 5001, -1, 1, RANGE_MAX, 1, 1));
		pending_readings.push_back(make_reading(RANGE_MAX, RATE_MIN, 1, 0, RATE_MAX, 0));
		pending_readings.push_back(make_reading(RANGE_MAX, RATE_MIN, 0, 0, RATE_MAX, 1));
		pending_readings.push_back(make_reading(12345, 77, 0, 54321, -77, 0));
		pending_readings.push_back(make_reading(0, 0, 0, RANGE_MAX, RATE_MAX, 1));
		pending_readings.push_back(make_reading(0, 5, 0, 0, 5, 0));
		pending_readings.push_back(make_reading(0, -1, 1, RANGE_MAX, 0, 0));
		pending_readings.push_back(make_reading(12345, 1000, 1, 12000, -1000, 1));
		pending_readings.push_back(make_reading(8388608, RATE_MIN, 1, 8388608, RATE_MIN, 1));
		pending_readings.push_back(make_reading(100, RATE_MAX, 1, 0, 0, 0));
		pending_readings.push_back(make_reading(100, RATE_MAX, 1, 5100, RATE_MIN, 1));
		pending_readings.push_back(make_reading(24'hAAAAAA, 21'h0AAAAA, 1,
			24'h555555, 21'h155555, 1));
		pending_readings.push_back(make_reading(24'h555555, 21'h155555, 1,
			24'h555555, 21'h0AAAAA, 1));
		drain_pipeline();

		queue_random(300, 1'b1);
		queue_random(260, 1'b0);

		// extremes of the registers
		set_registers(0, 0, 1);
		queue_random(200, 1'b1);
		set_registers(65535, RANGE_MAX, RANGE_MAX);
		queue_random(200, 1'b0);

		// zero slope base: rise, fall and no change
		set_registers(32768, 5000, 0);
		pending_readings.push_back(make_reading(1000, 0, 1, 0, 0, 0));
		pending_readings.push_back(make_reading(400, 0, 0, 400, 0, 1));
		pending_readings.push_back(make_reading(0, 0, 0, 0, 0, 0));
		pending_readings.push_back(make_reading(400, 3, 1, 400, 3, 1));
		drain_pipeline();
		queue_random(100, 1'b1);

		repeat (3) begin
			set_registers($urandom_range(0, 65535),
				$urandom_range(0, 1) ? $urandom_range(0, 20000) : ($urandom() & RANGE_MAX),
				$urandom_range(0, 1) ? $urandom_range(1, 100000)
					: $urandom_range(1, 32'(RANGE_MAX)));
			queue_random(200, 1'b1);
		end

		drain_pipeline();
		if (mismatch_cnt == 0)
			$display("dual_altimeter_fusion_core_test: PASS");
		else
			$display("dual_altimeter_fusion_core_test: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("dual_altimeter_fusion_core_test: FAIL");
		$finish;
	end

endmodule
